### rtl/gripper_command_frame_encoder_defines.svh
// assertion macros shared by the frame encoder checker
`ifndef GRIPPER_COMMAND_FRAME_ENCODER_DEFINES_SVH
`define GRIPPER_COMMAND_FRAME_ENCODER_DEFINES_SVH

// property checked only outside reset
`define GCFE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define GCFE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/gcfe_pkg.sv
// shared types, constants and functions of the gripper command frame encoder
`default_nettype none

package gcfe_pkg;

   // input op codes
   localparam logic [2:0] OP_REFERENCE = 3'd0;
   localparam logic [2:0] OP_STOP      = 3'd1;
   localparam logic [2:0] OP_ACK_ERROR = 3'd2;
   localparam logic [2:0] OP_GET_STATE = 3'd3;
   localparam logic [2:0] OP_MOVE      = 3'd4;

   // frame bytes
   localparam logic [7:0] SOF_BYTE       = 8'h05;
   localparam logic [7:0] CMD_REFERENCE  = 8'h92;
   localparam logic [7:0] CMD_STOP       = 8'h91;
   localparam logic [7:0] CMD_ACK_ERROR  = 8'h8b;
   localparam logic [7:0] CMD_GET_STATE  = 8'h95;
   localparam logic [7:0] CMD_MOVE       = 8'hb0;
   localparam logic [7:0] LEN_SHORT      = 8'h01;
   localparam logic [7:0] LEN_GET_STATE  = 8'h06;
   localparam logic [7:0] LEN_MOVE       = 8'h0d;
   localparam logic [7:0] STATE_TAIL     = 8'h01;

   // frame sizes in bytes, crc included
   localparam int FRAME_MIN_BYTES   = 6;
   localparam int FRAME_STATE_BYTES = 11;
   localparam int FRAME_MAX_BYTES   = 18;

   localparam logic [15:0] CRC_POLY   = 16'ha001;
   localparam logic [7:0]  FLOAT_BIAS = 8'd127;

   typedef enum logic [2:0] {
      KIND_REFERENCE,
      KIND_STOP,
      KIND_ACK_ERROR,
      KIND_GET_STATE,
      KIND_MOVE
   } kind_type;

   // classified command as handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [31:0] pos_word;
      logic [31:0] vel_word;
      logic [31:0] acc_word;
   } desc_type;

   // one byte of the reflected crc-16/arc
   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // exact single precision encoding of a small unsigned integer
   function automatic logic [31:0] int_to_single(logic [8:0] n);
      logic [3:0]  p;
      logic [31:0] shifted;
      logic [7:0]  expo;
      p = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (n[i]) p = 4'(i);
      end
      shifted = {23'd0, n} << (5'd23 - {1'b0, p});
      expo    = FLOAT_BIAS + {4'd0, p};
      if (n == 9'd0) return 32'd0;
      return {1'b0, expo, shifted[22:0]};
   endfunction

endpackage

`default_nettype wire

### rtl/gcfe_front.sv
// front end: accepts commands, drops unused codes, builds move words
`default_nettype none

module gcfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_op,
   input  wire logic [7:0]       req_goal_position,
   input  wire logic [7:0]       req_goal_velocity,
   input  wire logic [8:0]       req_goal_acceleration,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output gcfe_pkg::desc_type    push_desc
);

   logic               valid_ff, valid_in;
   gcfe_pkg::desc_type desc_ff, desc_in;
   logic               accept;
   logic               known_op;
   gcfe_pkg::kind_type kind;

   // hold off only while a command waits for queue space
   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_desc  = desc_ff;

   // classify op code
   always_comb begin
      known_op = 1'b1;
      kind     = gcfe_pkg::KIND_REFERENCE;
      case (req_op)
         gcfe_pkg::OP_REFERENCE: kind = gcfe_pkg::KIND_REFERENCE;
         gcfe_pkg::OP_STOP:      kind = gcfe_pkg::KIND_STOP;
         gcfe_pkg::OP_ACK_ERROR: kind = gcfe_pkg::KIND_ACK_ERROR;
         gcfe_pkg::OP_GET_STATE: kind = gcfe_pkg::KIND_GET_STATE;
         gcfe_pkg::OP_MOVE:      kind = gcfe_pkg::KIND_MOVE;
         default:                known_op = 1'b0;
      endcase
   end

   // stage register next value
   always_comb begin
      valid_in = valid_ff && !push_ready;
      desc_in  = desc_ff;
      if (accept) begin
         valid_in         = known_op;
         desc_in.kind     = kind;
         desc_in.pos_word = gcfe_pkg::int_to_single({1'b0, req_goal_position});
         desc_in.vel_word = gcfe_pkg::int_to_single({1'b0, req_goal_velocity});
         desc_in.acc_word = gcfe_pkg::int_to_single(req_goal_acceleration);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
   end

endmodule

`default_nettype wire

### rtl/gcfe_queue.sv
// two entry command queue between front and back
`default_nettype none

module gcfe_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire gcfe_pkg::desc_type  push_desc,
   output logic                     pop_valid,
   input  wire logic                pop_take,
   output gcfe_pkg::desc_type       pop_desc
);

   gcfe_pkg::desc_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_desc   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_take && pop_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

`default_nettype wire

### rtl/gcfe_back.sv
// back end: walks a frame byte by byte, runs the crc, drives the output register
`default_nettype none

module gcfe_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          module_id,
   input  wire logic                pop_valid,
   output logic                     pop_take,
   input  wire gcfe_pkg::desc_type  pop_desc,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_last
);

   logic               active_ff, active_in;
   gcfe_pkg::desc_type desc_ff, desc_in;
   logic [4:0]         idx_ff, idx_in;
   logic [15:0]        crc_ff, crc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               advance, emit, is_last, is_data, done;
   logic [4:0]         last_idx;
   logic [4:0]         off;
   logic [31:0]        word;
   logic [7:0]         data_byte, frame_byte;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = active_ff && advance;

   // frame length per command kind
   always_comb begin
      case (desc_ff.kind)
         gcfe_pkg::KIND_GET_STATE: last_idx = 5'(gcfe_pkg::FRAME_STATE_BYTES - 1);
         gcfe_pkg::KIND_MOVE:      last_idx = 5'(gcfe_pkg::FRAME_MAX_BYTES - 1);
         default:                  last_idx = 5'(gcfe_pkg::FRAME_MIN_BYTES - 1);
      endcase
   end

   assign is_last = (idx_ff == last_idx);
   assign is_data = (idx_ff < last_idx - 5'd1);
   assign done    = emit && is_last;
   assign pop_take = pop_valid && (!active_ff || done);

   // move payload word and byte lane
   assign off = idx_ff - 5'd4;
   always_comb begin
      case (off[3:2])
         2'd0:    word = desc_ff.pos_word;
         2'd1:    word = desc_ff.vel_word;
         default: word = desc_ff.acc_word;
      endcase
   end

   // header and payload bytes
   always_comb begin
      data_byte = 8'h00;
      case (idx_ff)
         5'd0: data_byte = gcfe_pkg::SOF_BYTE;
         5'd1: data_byte = module_id;
         5'd2: begin
            case (desc_ff.kind)
               gcfe_pkg::KIND_GET_STATE: data_byte = gcfe_pkg::LEN_GET_STATE;
               gcfe_pkg::KIND_MOVE:      data_byte = gcfe_pkg::LEN_MOVE;
               default:                  data_byte = gcfe_pkg::LEN_SHORT;
            endcase
         end
         5'd3: begin
            case (desc_ff.kind)
               gcfe_pkg::KIND_REFERENCE: data_byte = gcfe_pkg::CMD_REFERENCE;
               gcfe_pkg::KIND_STOP:      data_byte = gcfe_pkg::CMD_STOP;
               gcfe_pkg::KIND_ACK_ERROR: data_byte = gcfe_pkg::CMD_ACK_ERROR;
               gcfe_pkg::KIND_GET_STATE: data_byte = gcfe_pkg::CMD_GET_STATE;
               default:                  data_byte = gcfe_pkg::CMD_MOVE;
            endcase
         end
         default: begin
            if (desc_ff.kind == gcfe_pkg::KIND_MOVE) begin
               data_byte = word[8*off[1:0] +: 8];
            end else if (idx_ff == 5'd8) begin
               data_byte = gcfe_pkg::STATE_TAIL;
            end
         end
      endcase
   end

   // data bytes, then crc low, then crc high
   always_comb begin
      if (is_data)      frame_byte = data_byte;
      else if (is_last) frame_byte = crc_ff[15:8];
      else              frame_byte = crc_ff[7:0];
   end

   // sequencer next state
   always_comb begin
      active_in = active_ff;
      desc_in   = desc_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      if (pop_take) begin
         active_in = 1'b1;
         desc_in   = pop_desc;
         idx_in    = 5'd0;
         crc_in    = 16'd0;
      end else if (done) begin
         active_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 5'd1;
         if (is_data) crc_in = gcfe_pkg::crc_update(crc_ff, data_byte);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = emit;
         rsp_byte_in  = frame_byte;
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff     <= desc_in;
      idx_ff      <= idx_in;
      crc_ff      <= crc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_byte_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/gripper_command_frame_encoder.sv
// top level of the gripper command frame encoder
//
// Usage: each command beat on the req_ channel (op plus move arguments)
// becomes one serial frame on the rsp_ channel, one byte per beat, with
// rsp_last set on the high crc byte. Frames are 6 bytes for reference,
// stop and acknowledge, 11 bytes for get state and 18 bytes for a move.
// Op codes 5 to 7 are taken and produce no bytes.
// csr_wr_en/csr_wr_data set the module address byte; write it only while
// no frame is pending.
// Path: the first byte of a frame passes the front stage register, the queue
// entry, the sequencer registers and the output register to rsp_valid.
// Throughput: the byte sequencer sends one byte per cycle while rsp_stall
// is low; when the next command already waits in the queue, its frame
// follows its predecessor's last byte with no gap.
// A two entry command queue sits between the front end and the sequencer,
// so commands are taken while a frame is still going out.
// Reset clears the queue, the sequencer and the output, and the address
// byte returns to 0. A stall on rsp_ holds the current byte; while the
// queue is full and the front stage holds a command, req_stall is high.
`default_nettype none

module gripper_command_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_op,
   input  wire logic [7:0]  req_goal_position,
   input  wire logic [7:0]  req_goal_velocity,
   input  wire logic [8:0]  req_goal_acceleration,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0]         module_id_reg_ff;
   logic               push_valid, push_ready;
   gcfe_pkg::desc_type push_desc;
   logic               pop_valid, pop_take;
   gcfe_pkg::desc_type pop_desc;

   // module address register
   always_ff @(posedge clock) begin
      if (reset) begin
         module_id_reg_ff <= 8'd0;
      end else if (csr_wr_en) begin
         module_id_reg_ff <= csr_wr_data;
      end
   end

   gcfe_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_goal_position     (req_goal_position),
      .req_goal_velocity     (req_goal_velocity),
      .req_goal_acceleration (req_goal_acceleration),
      .push_valid            (push_valid),
      .push_ready            (push_ready),
      .push_desc             (push_desc)
   );

   gcfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_desc   (pop_desc)
   );

   gcfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .module_id   (module_id_reg_ff),
      .pop_valid   (pop_valid),
      .pop_take    (pop_take),
      .pop_desc    (pop_desc),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/gcfe_checker.sv
// port level checks of the frame encoder and their bind
`default_nettype none

`include "gripper_command_frame_encoder_defines.svh"

module gcfe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_last
);

   logic [4:0] beat_count_ff, beat_count_in;
   logic       rsp_beat;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // position of the current beat within its frame
   always_comb begin
      beat_count_in = beat_count_ff;
      if (rsp_beat) beat_count_in = rsp_last ? 5'd0 : beat_count_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_count_ff <= 5'd0;
      end else begin
         beat_count_ff <= beat_count_in;
      end
   end

   `GCFE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !req_stall, "output or stall active after reset")
   `GCFE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last), "stalled byte changed")
   `GCFE_ASSERT(a_frame_start, rsp_valid && beat_count_ff == 5'd0 |-> rsp_tx_byte == gcfe_pkg::SOF_BYTE, "frame does not open with start byte")
   `GCFE_ASSERT(a_frame_size, rsp_valid |-> beat_count_ff < 5'(gcfe_pkg::FRAME_MAX_BYTES) && (!rsp_last || beat_count_ff >= 5'(gcfe_pkg::FRAME_MIN_BYTES - 1)), "frame length out of range")

endmodule

bind gripper_command_frame_encoder gcfe_checker u_checker (.*);

`default_nettype wire
